/* src/bucket_index_builder_with_occ_filter_core_macros.svh */
// Assertion macros used by the file that checks this block.
`ifndef BUCKET_INDEX_BUILDER_WITH_OCC_FILTER_CORE_MACROS_SVH
`define BUCKET_INDEX_BUILDER_WITH_OCC_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BIBOF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bibof assertion failed");

// Next-cycle implication, disabled while in reset.
`define BIBOF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bibof assertion failed");

`endif

/* src/bibof_pkg.sv */
package bibof_pkg;

  localparam int GROUP_DEPTH     = 32;
  localparam int MAX_BUCKET_BITS = 30;

  localparam int IDX_W      = 5;
  localparam int SIZE_W     = 6;
  localparam int BUCKET_W   = 30;
  localparam int SEED_W     = 21;
  localparam int LOC_W      = 32;
  localparam int CHROM_W    = 10;
  localparam int KIND_W     = 2;
  localparam int MAXOCC_W   = 6;
  localparam int BBITS_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int ENTRY_W    = LOC_W + CHROM_W + 1;

  localparam logic [MAXOCC_W-1:0] MAXOCC_RESET = 6'd32;
  localparam logic [BBITS_W-1:0]  BBITS_RESET  = 5'd26;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_OCC     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BITS = 1'd1;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] SRC_ERR   = 2'd0;
  localparam logic [1:0] SRC_WR    = 2'd1;
  localparam logic [1:0] SRC_FILL  = 2'd2;
  localparam logic [1:0] SRC_FFILL = 2'd3;

  typedef struct packed {
    logic       cap;
    logic       gen;
    logic [1:0] src;
    logic       clr_idx;
    logic       adv;
    logic       upd;
    logic       clear;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic fin;
    logic close1_go;
    logic fill1_go;
    logic close2_go;
    logic ffill_go;
    logic last_idx;
    logic gen_ok;
    logic pend_v;
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LOC_W-1:0]    position;
    logic [BUCKET_W-1:0] bucket_first;
    logic [BUCKET_W-1:0] bucket_last;
    logic [SEED_W-1:0]   seed;
    logic [LOC_W-1:0]    location;
    logic [CHROM_W-1:0]  chrom;
    logic                strand;
  } res_t;

endpackage

/* src/bibof_ctrl.sv */
module bibof_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bibof_pkg::status_t st,
  output bibof_pkg::cmd_t    cmd
);
  import bibof_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FFILL = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       second_r, second_nxt;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_nxt  = state_r;
    second_nxt = second_r;
    case (state_r)
      S_IDLE: begin
        if (st.pend_v) begin
          if (st.gen_ok) begin
            cmd.flush = 1'b1;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.cap    = 1'b1;
            second_nxt = 1'b0;
            state_nxt  = S_ERR;
          end
        end
      end
      S_ERR: begin
        if (st.bad) begin
          if (st.gen_ok) begin
            cmd.gen    = 1'b1;
            cmd.src    = SRC_ERR;
            second_nxt = 1'b1;
            state_nxt  = S_CHK;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (second_r ? st.close2_go : st.close1_go) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = second_r ? S_FFILL : S_FILL;
        end
      end
      S_EMIT: begin
        if (st.gen_ok) begin
          cmd.gen = 1'b1;
          cmd.src = SRC_WR;
          if (st.last_idx) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = second_r ? S_FFILL : S_FILL;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      S_FILL: begin
        if (st.fill1_go) begin
          if (st.gen_ok) begin
            cmd.gen   = 1'b1;
            cmd.src   = SRC_FILL;
            state_nxt = S_UPD;
          end
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        second_nxt = 1'b1;
        state_nxt  = st.fin ? S_CHK : S_IDLE;
      end
      S_FFILL: begin
        if (!st.fin) begin
          state_nxt = S_IDLE;
        end else if (st.ffill_go) begin
          if (st.gen_ok) begin
            cmd.gen   = 1'b1;
            cmd.src   = SRC_FFILL;
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* src/bibof_dp.sv */
module bibof_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bibof_pkg::BUCKET_W-1:0]      in_bucket,
  input  logic [bibof_pkg::SEED_W-1:0]        in_seed,
  input  logic [bibof_pkg::LOC_W-1:0]         in_location,
  input  logic [bibof_pkg::CHROM_W-1:0]       in_chrom,
  input  logic                                in_strand,
  input  logic                                in_final_key,
  input  logic                                cfg_we,
  input  logic [bibof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bibof_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  bibof_pkg::cmd_t                     cmd,
  output bibof_pkg::status_t                  st,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [bibof_pkg::KIND_W-1:0]        out_kind,
  output logic [bibof_pkg::LOC_W-1:0]         out_position,
  output logic [bibof_pkg::BUCKET_W-1:0]      out_bucket_first,
  output logic [bibof_pkg::BUCKET_W-1:0]      out_bucket_last,
  output logic [bibof_pkg::SEED_W-1:0]        out_seed_out,
  output logic [bibof_pkg::LOC_W-1:0]         out_location_out,
  output logic [bibof_pkg::CHROM_W-1:0]       out_chrom_out,
  output logic                                out_strand_out,
  output logic                                out_run_end
);
  import bibof_pkg::*;

  logic [MAXOCC_W-1:0] max_occ_r;
  logic [BBITS_W-1:0]  bbits_r;

  logic [BUCKET_W-1:0] cap_bucket_r;
  logic [SEED_W-1:0]   cap_seed_r;
  logic [LOC_W-1:0]    cap_loc_r;
  logic [CHROM_W-1:0]  cap_chrom_r;
  logic                cap_strand_r;
  logic                cap_fin_r;

  logic                started_r, started_nxt;
  logic [BUCKET_W-1:0] gbucket_r, gbucket_nxt;
  logic [SEED_W-1:0]   gseed_r, gseed_nxt;
  logic [SIZE_W-1:0]   gsize_r, gsize_nxt;
  logic [LOC_W-1:0]    kept_r, kept_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic [ENTRY_W-1:0]  store [GROUP_DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  packed_in;

  logic [BBITS_W-1:0]  bits_eff;
  logic [BUCKET_W-1:0] map_end;
  logic [SIZE_W-1:0]   limit;
  logic                keep;
  logic                same;
  logic                bad;
  logic                out_free;

  res_t res_new;
  res_t pend_r;
  logic pend_v_r, pend_v_nxt;
  res_t out_r;
  logic out_valid_r, out_valid_nxt;
  logic run_end_r;

  always_comb begin
    if (bbits_r < BBITS_W'(1)) begin
      bits_eff = BBITS_W'(1);
    end else if (bbits_r > BBITS_W'(MAX_BUCKET_BITS)) begin
      bits_eff = BBITS_W'(MAX_BUCKET_BITS);
    end else begin
      bits_eff = bbits_r;
    end
  end

  assign map_end = ~({BUCKET_W{1'b1}} << bits_eff);

  assign limit = (max_occ_r > SIZE_W'(GROUP_DEPTH)) ? SIZE_W'(GROUP_DEPTH) : max_occ_r;
  assign keep  = (gsize_r <= limit);
  assign same  = started_r && (cap_bucket_r == gbucket_r) && (cap_seed_r == gseed_r);
  assign bad   = (cap_bucket_r > map_end) ||
                 (started_r && ((cap_bucket_r < gbucket_r) ||
                                ((cap_bucket_r == gbucket_r) && (cap_seed_r < gseed_r))));

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    st           = '0;
    st.bad       = bad;
    st.fin       = cap_fin_r;
    st.close1_go = !bad && started_r && !same && keep;
    st.fill1_go  = !bad && (started_r ? (!same && (cap_bucket_r > gbucket_r))
                                      : (cap_bucket_r != '0));
    st.close2_go = cap_fin_r && started_r && keep;
    st.ffill_go  = !started_r || (gbucket_r <= map_end);
    st.last_idx  = ({1'b0, idx_r} == (gsize_r - SIZE_W'(1)));
    st.gen_ok    = !pend_v_r || out_free;
    st.pend_v    = pend_v_r;
  end

  assign packed_in = {cap_strand_r, cap_chrom_r, cap_loc_r};

  always_comb begin
    if (cmd.clr_idx) begin
      rd_addr = '0;
    end else if (cmd.adv) begin
      rd_addr = idx_r + IDX_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  assign idx_nxt = rd_addr;

  always_comb begin
    res_new = '0;
    case (cmd.src)
      SRC_ERR: begin
        res_new.kind         = KIND_ERROR;
        res_new.bucket_first = cap_bucket_r;
        res_new.bucket_last  = cap_bucket_r;
        res_new.seed         = cap_seed_r;
        res_new.location     = cap_loc_r;
        res_new.chrom        = cap_chrom_r;
        res_new.strand       = cap_strand_r;
      end
      SRC_WR: begin
        res_new.kind         = KIND_WRITE;
        res_new.position     = kept_r;
        res_new.bucket_first = gbucket_r;
        res_new.bucket_last  = gbucket_r;
        res_new.seed         = gseed_r;
        res_new.location     = rd_data_r[LOC_W-1:0];
        res_new.chrom        = rd_data_r[LOC_W+CHROM_W-1:LOC_W];
        res_new.strand       = rd_data_r[ENTRY_W-1];
      end
      SRC_FILL: begin
        res_new.kind         = KIND_FILL;
        res_new.position     = kept_r;
        res_new.bucket_first = started_r ? gbucket_r : '0;
        res_new.bucket_last  = cap_bucket_r - BUCKET_W'(1);
      end
      SRC_FFILL: begin
        res_new.kind         = KIND_FILL;
        res_new.position     = kept_r;
        res_new.bucket_first = started_r ? gbucket_r : '0;
        res_new.bucket_last  = map_end;
      end
      default: begin
        res_new = '0;
      end
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    gbucket_nxt = gbucket_r;
    gseed_nxt   = gseed_r;
    gsize_nxt   = gsize_r;
    kept_nxt    = kept_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    if (cmd.gen && (cmd.src == SRC_WR)) begin
      kept_nxt = kept_r + LOC_W'(1);
    end
    if (cmd.upd && !bad) begin
      if (same) begin
        if (gsize_r < SIZE_W'(GROUP_DEPTH)) begin
          wr_en     = 1'b1;
          wr_addr   = gsize_r[IDX_W-1:0];
          gsize_nxt = gsize_r + SIZE_W'(1);
        end else if (gsize_r == SIZE_W'(GROUP_DEPTH)) begin
          gsize_nxt = gsize_r + SIZE_W'(1);
        end
      end else begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        started_nxt = 1'b1;
        gbucket_nxt = cap_bucket_r;
        gseed_nxt   = cap_seed_r;
        gsize_nxt   = SIZE_W'(1);
      end
    end
    if (cmd.clear) begin
      started_nxt = 1'b0;
      gbucket_nxt = '0;
      gseed_nxt   = '0;
      gsize_nxt   = '0;
      kept_nxt    = '0;
    end
  end

  always_comb begin
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r;
    if ((cmd.gen && pend_v_r) || cmd.flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.gen) begin
      pend_v_nxt = 1'b1;
    end else if (cmd.flush) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= packed_in;
    end
    rd_data_r <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_bucket_r <= in_bucket;
      cap_seed_r   <= in_seed;
      cap_loc_r    <= in_location;
      cap_chrom_r  <= in_chrom;
      cap_strand_r <= in_strand;
      cap_fin_r    <= in_final_key;
    end
    if (cmd.gen) begin
      pend_r <= res_new;
    end
    if ((cmd.gen && pend_v_r) || cmd.flush) begin
      out_r     <= pend_r;
      run_end_r <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_occ_r   <= MAXOCC_RESET;
      bbits_r     <= BBITS_RESET;
      started_r   <= 1'b0;
      gbucket_r   <= '0;
      gseed_r     <= '0;
      gsize_r     <= '0;
      kept_r      <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_OCC:     max_occ_r <= cfg_data;
          REG_BUCKET_BITS: bbits_r   <= cfg_data[BBITS_W-1:0];
          default: begin
          end
        endcase
      end
      started_r   <= started_nxt;
      gbucket_r   <= gbucket_nxt;
      gseed_r     <= gseed_nxt;
      gsize_r     <= gsize_nxt;
      kept_r      <= kept_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_position     = out_r.position;
  assign out_bucket_first = out_r.bucket_first;
  assign out_bucket_last  = out_r.bucket_last;
  assign out_seed_out     = out_r.seed;
  assign out_location_out = out_r.location;
  assign out_chrom_out    = out_r.chrom;
  assign out_strand_out   = out_r.strand;
  assign out_run_end      = run_end_r;

endmodule

/* src/bucket_index_builder_with_occ_filter_core.sv */
// Builds a bucket offset table from seed keys sorted by bucket and then seed. Keys sharing
// bucket and seed are buffered as a group in a 32-entry store; a closed group is written out
// as key transactions only if it has at most max_occurrence members (a limit capped at 32),
// and map range fill transactions are emitted so that map entry b holds the kept key count
// up to bucket b. Keys out of order or beyond the map give an error transaction and are
// dropped. One input transaction is handled at a time; the next is taken only once the last
// is done. An item that closes a group writes its buffered keys out one at a time, as the
// group store has a single read port, and a final key also writes out the last group's keys
// if it is kept, and a final fill. Output back-pressure can stall any of these steps. The
// last result of each input carries run_end.
`include "bucket_index_builder_with_occ_filter_core_macros.svh"

module bucket_index_builder_with_occ_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bibof_pkg::BUCKET_W-1:0]      in_bucket,
  input  logic [bibof_pkg::SEED_W-1:0]        in_seed,
  input  logic [bibof_pkg::LOC_W-1:0]         in_location,
  input  logic [bibof_pkg::CHROM_W-1:0]       in_chrom,
  input  logic                                in_strand,
  input  logic                                in_final_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bibof_pkg::KIND_W-1:0]        out_kind,
  output logic [bibof_pkg::LOC_W-1:0]         out_position,
  output logic [bibof_pkg::BUCKET_W-1:0]      out_bucket_first,
  output logic [bibof_pkg::BUCKET_W-1:0]      out_bucket_last,
  output logic [bibof_pkg::SEED_W-1:0]        out_seed_out,
  output logic [bibof_pkg::LOC_W-1:0]         out_location_out,
  output logic [bibof_pkg::CHROM_W-1:0]       out_chrom_out,
  output logic                                out_strand_out,
  output logic                                out_run_end,
  input  logic                                cfg_we,
  input  logic [bibof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bibof_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bibof_pkg::*;

  cmd_t    cmd;
  status_t st;

  bibof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bibof_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_bucket        (in_bucket),
    .in_seed          (in_seed),
    .in_location      (in_location),
    .in_chrom         (in_chrom),
    .in_strand        (in_strand),
    .in_final_key     (in_final_key),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_position     (out_position),
    .out_bucket_first (out_bucket_first),
    .out_bucket_last  (out_bucket_last),
    .out_seed_out     (out_seed_out),
    .out_location_out (out_location_out),
    .out_chrom_out    (out_chrom_out),
    .out_strand_out   (out_strand_out),
    .out_run_end      (out_run_end)
  );

  `BIBOF_ASSERT_IMP(a_gen_room, cmd.gen, st.gen_ok)
  `BIBOF_ASSERT_IMP(a_flush_room, cmd.flush, (!out_valid || out_ready))
  `BIBOF_ASSERT_NXT(a_one_item, (in_valid && in_ready), !in_ready)
  `BIBOF_ASSERT_IMP(a_fill_clean, (out_valid && (out_kind == KIND_FILL)), ((out_seed_out == '0) && (out_location_out == '0)))

endmodule
